// ----- hdl/sphav_pkg.sv -----
// shared types, constants and arithmetic helpers for the viscosity pair engine
package sphav_pkg;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_PAIR  = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_IDLE  = 2'd3;

	localparam logic [3:0] ATTR_POS0   = 4'd0;
	localparam logic [3:0] ATTR_POS2   = 4'd2;
	localparam logic [3:0] ATTR_VEL0   = 4'd3;
	localparam logic [3:0] ATTR_VEL2   = 4'd5;
	localparam logic [3:0] ATTR_DENS   = 4'd6;
	localparam logic [3:0] ATTR_SMOOTH = 4'd7;
	localparam logic [3:0] ATTR_SOUND  = 4'd8;
	localparam logic [3:0] ATTR_MASS   = 4'd9;
	localparam logic [3:0] ATTR_KIND   = 4'd10;
	localparam logic [3:0] ATTR_FRC0   = 4'd11;
	localparam logic [3:0] ATTR_FRC2   = 4'd13;

	localparam logic       CFG_ALPHA = 1'b0;
	localparam logic       CFG_ETA   = 1'b1;

	localparam logic [16:0] ALPHA_RESET = 17'd3277;
	localparam logic [16:0] ETA_RESET   = 17'd655;

	localparam int TDATA_IN_W = 160;

	// quotient bits of the force coefficient division
	localparam int DIV_BITS = 48;

	// fields of one input item
	typedef struct packed {
		logic signed [31:0] grad_z;
		logic signed [31:0] grad_y;
		logic signed [31:0] grad_x;
		logic signed [31:0] word_value;
		logic [3:0]         attribute;
		logic [9:0]         second_index;
		logic [9:0]         first_index;
		logic [1:0]         cmd;
	} item_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		logic signed [31:0] r;
		if (x > 66'sd2147483647)
			r = 32'sh7fffffff;
		else if (x < -66'sd2147483648)
			r = 32'sh80000000;
		else
			r = x[31:0];
		return r;
	endfunction

endpackage

// ----- hdl/sphav_ram.sv -----
// generic single-port ram with registered read
module sphav_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// ----- hdl/sph_artificial_viscosity_pairs.sv -----
// top level of the artificial viscosity pair engine
//
//  channel  | dir | handshake                   | payload
//  s_axis   | in  | s_axis_tvalid/s_axis_tready | s_axis_tdata: item fields
//  m_axis   | out | m_axis_tvalid/m_axis_tready | m_axis_tdata: read_value
//  cfg      | in  | cfg_valid/cfg_ready         | cfg_index, cfg_data
//
// a write item is written in the cycle it is accepted; a read item passes through ST_RD,
// where the word is registered, to ST_OUT, which holds it until taken. a full pair item
// holds the input through kind fetch, per component differences and products, scalar fetch,
// products, the divider and the per component force update; a skipped pair leaves earlier.
// the single 32x32 multiplier and the one bit a cycle divider set the pair time.
// the input side is not ready while an item is in progress or a result waits;
// cfg is taken only when idle with no item offered.
// reset clears registers only; particle data is undefined until written.
module sph_artificial_viscosity_pairs
	import sphav_pkg::*;
#(
	parameter int DIM           = 3,
	parameter int NUM_PARTICLES = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// cmd, first_index, second_index, attribute, word_value, grad_x, grad_y, grad_z, zero fill
	input  logic [TDATA_IN_W-1:0] s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// read_value
	output logic [31:0]           m_axis_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [16:0]           cfg_data
);
	localparam int PW    = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
	// particle record: 16 word slots per particle
	localparam int AW    = PW + 4;
	localparam int DEPTH = NUM_PARTICLES * 16;

	// sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD   = 4'd1;
	localparam logic [3:0] ST_OUT  = 4'd2;
	localparam logic [3:0] ST_KIND = 4'd3;
	localparam logic [3:0] ST_GEOM = 4'd4;
	localparam logic [3:0] ST_SCAL = 4'd5;
	localparam logic [3:0] ST_MUL  = 4'd6;
	localparam logic [3:0] ST_DIV  = 4'd7;
	localparam logic [3:0] ST_FRC  = 4'd8;

	item_t it;
	assign it = item_t'(s_axis_tdata[$bits(item_t)-1:0]);

	logic [3:0]  state_q;
	item_t       item_q;
	logic [16:0] alpha_q, eta_q;
	logic [31:0] out_q;
	logic [3:0]  step_q;
	logic [1:0]  comp_q;
	logic [7:0]  ki_q;

	// operands and intermediate terms
	logic signed [31:0] va_q, dx_q, dv_q;
	logic signed [33:0] vdw_q, rrw_q;
	logic signed [31:0] rho_q, h_q, c_q, mi_q, mj_q;
	logic signed [31:0] t1_q, e2_q, num_q, den_q, tq_q;

	// shared multiplier: Q16.16 product, floor shift, saturated
	logic signed [31:0] ma, mb;
	logic signed [63:0] mp;
	logic signed [31:0] mq;
	assign mp = ma * mb;
	assign mq = sat32(66'(mp >>> 16));

	// restoring divider on magnitudes
	logic [DIV_BITS-1:0] dquo_q;
	logic [31:0]         drem_q, dden_q;
	logic                dneg_q;
	logic [5:0]          dcnt_q;
	logic [32:0]         dtrial;
	logic                dge;
	logic [32:0]         ddiff;
	logic [31:0]         nmag, dmag;

	assign dtrial = {drem_q, dquo_q[DIV_BITS-1]};
	assign dge    = dtrial >= {1'b0, dden_q};
	assign ddiff  = dtrial - {1'b0, dden_q};
	assign nmag   = num_q[31] ? (~num_q + 32'd1) : num_q;
	assign dmag   = den_q[31] ? (~den_q + 32'd1) : den_q;

	// ram
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [31:0]   ram_wdata, ram_rdata;
	logic signed [31:0] rdata_s;
	assign rdata_s = ram_rdata;

	sphav_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	function automatic logic [AW-1:0] slot(input logic [9:0] p, input logic [3:0] a);
		return {PW'(p), a};
	endfunction

	logic in_range_i, in_range_j;
	assign in_range_i = 32'(item_q.first_index) < NUM_PARTICLES;
	assign in_range_j = 32'(item_q.second_index) < NUM_PARTICLES;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = (state_q == ST_IDLE) && !s_axis_tvalid;
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = out_q;

	// sums over components, then the terms built from them
	logic signed [31:0] vdotr, rr, negv, rre, g_sel;
	logic               last_comp;
	assign vdotr     = sat32(66'(vdw_q));
	assign rr        = sat32(66'(rrw_q));
	assign negv      = sat32(-66'(vdotr));
	assign rre       = sat32(66'(rr) + 66'(e2_q));
	assign last_comp = (32'(comp_q) == 32'(DIM - 1));

	always_comb begin
		case (comp_q)
			2'd0:    g_sel = item_q.grad_x;
			2'd1:    g_sel = item_q.grad_y;
			default: g_sel = item_q.grad_z;
		endcase
	end

	// multiplier operand selection
	always_comb begin
		ma = dv_q;
		mb = dx_q;
		case (state_q)
			ST_GEOM: if (step_q == 4'd6) begin
				ma = dx_q;
				mb = dx_q;
			end
			ST_MUL: begin
				case (step_q)
					4'd0: begin ma = 32'(eta_q); mb = h_q; end
					4'd1: begin ma = t1_q; mb = h_q; end
					4'd2: begin ma = 32'(alpha_q); mb = h_q; end
					4'd3: begin ma = t1_q; mb = c_q; end
					4'd4: begin ma = t1_q; mb = negv; end
					4'd5: begin ma = rho_q; mb = rre; end
					default: ;
				endcase
			end
			ST_FRC: begin
				case (step_q)
					4'd0: begin ma = mj_q; mb = tq_q; end
					4'd1: begin ma = t1_q; mb = g_sel; end
					4'd2: begin ma = mi_q; mb = tq_q; end
					4'd3: begin ma = t1_q; mb = g_sel; end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	logic [31:0] rd_word;
	always_comb begin
		rd_word = ram_rdata;
		if (item_q.attribute == ATTR_KIND)
			rd_word = {{24{ram_rdata[7]}}, ram_rdata[7:0]};
		if (!in_range_i || item_q.attribute > ATTR_FRC2)
			rd_word = '0;
	end

	// ram address, write enable and write data
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = slot(item_q.first_index, item_q.attribute);
		ram_wdata = item_q.word_value;
		case (state_q)
			ST_IDLE: begin
				ram_addr = slot(it.first_index, it.attribute);
				if (s_axis_tvalid && it.cmd == CMD_WRITE &&
					32'(it.first_index) < NUM_PARTICLES && it.attribute <= ATTR_FRC2) begin
					ram_we    = 1'b1;
					ram_wdata = (it.attribute == ATTR_KIND) ? 32'(it.word_value[7:0])
						: it.word_value;
				end
			end
			ST_KIND:
				ram_addr = slot((step_q == 4'd0) ? item_q.first_index : item_q.second_index,
					ATTR_KIND);
			ST_GEOM: begin
				case (step_q)
					4'd0: ram_addr = slot(item_q.first_index, ATTR_POS0 + {2'b00, comp_q});
					4'd1: ram_addr = slot(item_q.second_index, ATTR_POS0 + {2'b00, comp_q});
					4'd2: ram_addr = slot(item_q.first_index, ATTR_VEL0 + {2'b00, comp_q});
					default: ram_addr = slot(item_q.second_index, ATTR_VEL0 + {2'b00, comp_q});
				endcase
			end
			// dens, smooth, sound, mass of i then j
			ST_SCAL:
				ram_addr = slot(step_q[0] ? item_q.second_index : item_q.first_index,
					ATTR_DENS + {1'b0, step_q[3:1]});
			ST_FRC: begin
				if (step_q <= 4'd2) begin
					ram_addr  = slot(item_q.first_index, ATTR_FRC0 + {2'b00, comp_q});
					ram_we    = (step_q == 4'd2);
					ram_wdata = sat32(66'(rdata_s) - 66'(t1_q));
				end else begin
					ram_addr  = slot(item_q.second_index, ATTR_FRC0 + {2'b00, comp_q});
					ram_we    = (step_q == 4'd4);
					ram_wdata = sat32(66'(rdata_s) + 66'(t1_q));
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			item_q  <= '0;
			alpha_q <= ALPHA_RESET;
			eta_q   <= ETA_RESET;
			out_q   <= '0;
			step_q  <= '0;
			comp_q  <= '0;
			ki_q    <= '0;
			va_q    <= '0;
			dx_q    <= '0;
			dv_q    <= '0;
			vdw_q   <= '0;
			rrw_q   <= '0;
			rho_q   <= '0;
			h_q     <= '0;
			c_q     <= '0;
			mi_q    <= '0;
			mj_q    <= '0;
			t1_q    <= '0;
			e2_q    <= '0;
			num_q   <= '0;
			den_q   <= '0;
			tq_q    <= '0;
			dquo_q  <= '0;
			drem_q  <= '0;
			dden_q  <= '0;
			dneg_q  <= 1'b0;
			dcnt_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_ALPHA) alpha_q <= cfg_data;
				else eta_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: if (s_axis_tvalid) begin
					item_q <= it;
					step_q <= '0;
					comp_q <= '0;
					case (it.cmd)
						CMD_READ: state_q <= ST_RD;
						CMD_PAIR: state_q <= ST_KIND;
						default:  state_q <= ST_IDLE;
					endcase
				end
				ST_RD: begin
					out_q   <= rd_word;
					state_q <= ST_OUT;
				end
				ST_OUT: if (m_axis_tready) state_q <= ST_IDLE;
				ST_KIND: begin
					// kind of i arrives at step 1, kind of j at step 2
					step_q <= step_q + 4'd1;
					if (step_q == 4'd1) ki_q <= ram_rdata[7:0];
					if (step_q == 4'd2) begin
						step_q <= '0;
						comp_q <= '0;
						vdw_q  <= '0;
						rrw_q  <= '0;
						if (!in_range_i || !in_range_j || ki_q[7] ||
							!((ki_q == 8'd1 && ram_rdata[7:0] == 8'd1) ||
							(ki_q == 8'd8 && ram_rdata[7:0] == 8'd8)))
							state_q <= ST_IDLE;
						else
							state_q <= ST_GEOM;
					end
				end
				ST_GEOM: begin
					step_q <= step_q + 4'd1;
					case (step_q)
						4'd1: va_q <= rdata_s;
						4'd2: dx_q <= sat32(66'(va_q) - 66'(rdata_s));
						4'd3: va_q <= rdata_s;
						4'd4: dv_q <= sat32(66'(va_q) - 66'(rdata_s));
						4'd5: vdw_q <= vdw_q + 34'(mq);
						4'd6: begin
							rrw_q  <= rrw_q + 34'(mq);
							step_q <= '0;
							if (last_comp)
								state_q <= ST_SCAL;
							else
								comp_q <= comp_q + 2'd1;
						end
						default: ;
					endcase
				end
				ST_SCAL: begin
					step_q <= step_q + 4'd1;
					case (step_q)
						// particles moving apart: nothing to do
						4'd0: if (vdotr >= 0) state_q <= ST_IDLE;
						4'd1, 4'd3, 4'd5: va_q <= rdata_s;
						4'd2: rho_q <= 32'((66'(va_q) + 66'(rdata_s)) >>> 1);
						4'd4: h_q   <= 32'((66'(va_q) + 66'(rdata_s)) >>> 1);
						4'd6: c_q   <= 32'((66'(va_q) + 66'(rdata_s)) >>> 1);
						4'd7: mi_q  <= rdata_s;
						4'd8: begin
							mj_q    <= rdata_s;
							step_q  <= '0;
							state_q <= ST_MUL;
						end
						default: ;
					endcase
				end
				ST_MUL: begin
					step_q <= step_q + 4'd1;
					case (step_q)
						4'd0, 4'd2, 4'd3: t1_q <= mq;
						4'd1: e2_q  <= mq;
						4'd4: num_q <= mq;
						4'd5: den_q <= mq;
						4'd6: begin
							// zero divisor drops the pair
							if (den_q == 0)
								state_q <= ST_IDLE;
							else begin
								dquo_q  <= {nmag, 16'b0};
								drem_q  <= '0;
								dden_q  <= dmag;
								dneg_q  <= num_q[31] ^ den_q[31];
								dcnt_q  <= '0;
								state_q <= ST_DIV;
							end
						end
						default: ;
					endcase
				end
				ST_DIV: begin
					if (dcnt_q == 6'(DIV_BITS)) begin
						tq_q    <= sat32(dneg_q ? -66'(dquo_q) : 66'(dquo_q));
						step_q  <= '0;
						comp_q  <= '0;
						state_q <= ST_FRC;
					end else begin
						drem_q <= dge ? ddiff[31:0] : dtrial[31:0];
						dquo_q <= {dquo_q[DIV_BITS-2:0], dge};
						dcnt_q <= dcnt_q + 6'd1;
					end
				end
				ST_FRC: begin
					// steps 0-2 update i, steps 3-4 update j
					step_q <= step_q + 4'd1;
					if (step_q <= 4'd3)
						t1_q <= mq;
					if (step_q == 4'd4) begin
						step_q <= '0;
						if (last_comp)
							state_q <= ST_IDLE;
						else
							comp_q <= comp_q + 2'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- bench/tb_sph_artificial_viscosity_pairs.sv -----
// self-checking bench for the artificial viscosity pair engine, with a built-in predictor
module tb_sph_artificial_viscosity_pairs import sphav_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPART = 1024;
	localparam int NDIM = 3;
	localparam int CYCLE_LIMIT = 2000000;
	// a pair item gives no result, so allow well over the length of a full pair item
	localparam int SETTLE_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// cmd, first_index, second_index, attribute, word_value, grad_x, grad_y, grad_z, zero fill
	logic [TDATA_IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// read_value
	logic [31:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = CFG_ALPHA;
	logic [16:0] cfg_data = '0;

	sph_artificial_viscosity_pairs dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// predictor state: its own copy of the particle records and coefficients
	// ---------------------------------------------------------------
	int pos_m [NDIM][NPART];
	int vel_m [NDIM][NPART];
	int frc_m [NDIM][NPART];
	int dens_m [NPART];
	int smooth_m [NPART];
	int sound_m [NPART];
	int mass_m [NPART];
	logic signed [7:0] kind_m [NPART];
	int alpha_m = int'(ALPHA_RESET);
	int eta_m = int'(ETA_RESET);

	item_t item_q[$];	// items waiting for the driver
	int read_q[$];		// read values still to come back
	int n_err = 0;
	bit quiet = 1'b0;	// no gaps and no stalls while set

	// stimulus-side bookkeeping: which words have been written, so reads and
	// pairs never touch an undefined entry
	bit wr_ok [16][NPART];
	int wr_keys[$];
	int pool[$];

	function automatic int clip32(input longint x);
		if (x > 64'sd2147483647)
			return 32'sh7fffffff;
		if (x < -64'sd2147483648)
			return 32'sh80000000;
		return int'(x);
	endfunction

	// Q16.16 product, floor on the shift, saturated
	function automatic int q_mul(input int a, input int b);
		longint p;
		p = longint'(a) * longint'(b);
		return clip32(p >>> 16);
	endfunction

	function automatic int half_sum(input int a, input int b);
		longint s;
		s = longint'(a) + longint'(b);
		return int'(s >>> 1);
	endfunction

	// viscosity term for one pair, accumulated into both force vectors
	task automatic visc_apply(input int i, input int j, input int g[NDIM]);
		longint vd, r2, t;
		int dv, dx, vdotr, rr, rho, h, c, eta2, num, den, tv, di, dj;
		vd = 0;
		r2 = 0;
		if (kind_m[i] < 0)
			return;
		if (!((kind_m[i] == 1 && kind_m[j] == 1) || (kind_m[i] == 8 && kind_m[j] == 8)))
			return;
		for (int l = 0; l < NDIM; l++) begin
			dv = clip32(longint'(vel_m[l][i]) - vel_m[l][j]);
			dx = clip32(longint'(pos_m[l][i]) - pos_m[l][j]);
			vd += q_mul(dv, dx);
			r2 += q_mul(dx, dx);
		end
		vdotr = clip32(vd);
		rr = clip32(r2);
		// particles moving apart feel no viscosity
		if (vdotr >= 0)
			return;
		rho = half_sum(dens_m[i], dens_m[j]);
		h = half_sum(smooth_m[i], smooth_m[j]);
		c = half_sum(sound_m[i], sound_m[j]);
		eta2 = q_mul(q_mul(eta_m, h), h);
		num = q_mul(q_mul(q_mul(alpha_m, h), c), clip32(-longint'(vdotr)));
		den = q_mul(rho, clip32(longint'(rr) + eta2));
		// zero divisor: pair dropped
		if (den == 0)
			return;
		t = (longint'(num) * 65536) / longint'(den);
		tv = clip32(t);
		for (int l = 0; l < NDIM; l++) begin
			di = q_mul(q_mul(mass_m[j], tv), g[l]);
			dj = q_mul(q_mul(mass_m[i], tv), g[l]);
			frc_m[l][i] = clip32(longint'(frc_m[l][i]) - di);
			frc_m[l][j] = clip32(longint'(frc_m[l][j]) + dj);
		end
	endtask

	task automatic predict_item(input item_t it);
		int p, a, w, r;
		int g[NDIM];
		p = it.first_index;
		a = it.attribute;
		w = it.word_value;
		r = 0;
		case (it.cmd)
			CMD_WRITE: begin
				if (a <= ATTR_POS2) pos_m[a][p] = w;
				else if (a <= ATTR_VEL2) vel_m[a - ATTR_VEL0][p] = w;
				else if (a == ATTR_DENS) dens_m[p] = w;
				else if (a == ATTR_SMOOTH) smooth_m[p] = w;
				else if (a == ATTR_SOUND) sound_m[p] = w;
				else if (a == ATTR_MASS) mass_m[p] = w;
				else if (a == ATTR_KIND) kind_m[p] = w[7:0];
				else if (a <= ATTR_FRC2) frc_m[a - ATTR_FRC0][p] = w;
			end
			CMD_PAIR: begin
				g[0] = it.grad_x;
				g[1] = it.grad_y;
				g[2] = it.grad_z;
				visc_apply(p, it.second_index, g);
			end
			CMD_READ: begin
				if (a <= ATTR_POS2) r = pos_m[a][p];
				else if (a <= ATTR_VEL2) r = vel_m[a - ATTR_VEL0][p];
				else if (a == ATTR_DENS) r = dens_m[p];
				else if (a == ATTR_SMOOTH) r = smooth_m[p];
				else if (a == ATTR_SOUND) r = sound_m[p];
				else if (a == ATTR_MASS) r = mass_m[p];
				else if (a == ATTR_KIND) r = kind_m[p];
				else if (a <= ATTR_FRC2) r = frc_m[a - ATTR_FRC0][p];
				read_q.push_back(r);
			end
			default: ;
		endcase
	endtask

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	// ---------------------------------------------------------------
	// input driver: changes at the falling edge, fed from item_q
	// ---------------------------------------------------------------
	bit in_fire = 1'b0;
	int in_gap = 0;

	always @(negedge clk) begin
		if (arst_n && !(s_axis_tvalid && !in_fire)) begin
			if (in_gap > 0) begin
				s_axis_tvalid <= 1'b0;
				in_gap--;
			end else if (item_q.size() > 0) begin
				s_axis_tdata <= TDATA_IN_W'(item_q.pop_front());
				s_axis_tvalid <= 1'b1;
				in_gap = gap_len();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	int out_hold = 0;
	always @(negedge clk) begin
		if (out_hold > 0) begin
			m_axis_tready <= 1'b0;
			out_hold--;
		end else begin
			m_axis_tready <= 1'b1;
			out_hold = gap_len();
		end
	end

	// ---------------------------------------------------------------
	// monitor: accepted items go to the predictor, results are checked
	// ---------------------------------------------------------------
	int cycles = 0;
	always @(posedge clk) begin
		in_fire = s_axis_tvalid && s_axis_tready;
		if (in_fire)
			predict_item(item_t'(s_axis_tdata[$bits(item_t)-1:0]));
		if (m_axis_tvalid && m_axis_tready) begin
			if (read_q.size() == 0) begin
				$error("read_value: no item expected, got %h", m_axis_tdata);
				n_err++;
			end else begin
				int want;
				want = read_q.pop_front();
				if (m_axis_tdata !== want) begin
					$error("read_value: expected %h, got %h", want, m_axis_tdata);
					n_err++;
				end
			end
		end
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_sph_artificial_viscosity_pairs: done, errors");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	function automatic item_t make_item(input logic [1:0] c, input int i, input int j,
			input int a, input int w);
		item_t it;
		it.cmd = c;
		it.first_index = 10'(i);
		it.second_index = 10'(j);
		it.attribute = 4'(a);
		it.word_value = w;
		it.grad_x = $urandom;
		it.grad_y = $urandom;
		it.grad_z = $urandom;
		return it;
	endfunction

	task automatic put_write(input int i, input int a, input int w);
		item_q.push_back(make_item(CMD_WRITE, i, $urandom_range(0, NPART - 1), a, w));
		if (a <= ATTR_FRC2 && !wr_ok[a][i]) begin
			wr_ok[a][i] = 1'b1;
			wr_keys.push_back(a * NPART + i);
		end
	endtask

	task automatic put_read(input int i, input int a);
		item_q.push_back(make_item(CMD_READ, i, $urandom_range(0, NPART - 1), a, $urandom));
	endtask

	// gradient mostly within about one unit, sometimes any 32-bit value
	function automatic int rand_grad();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return int'($urandom_range(0, 131072)) - 65536;
	endfunction

	task automatic put_pair(input int i, input int j);
		item_t it;
		it = make_item(CMD_PAIR, i, j, $urandom_range(0, 15), $urandom);
		it.grad_x = rand_grad();
		it.grad_y = rand_grad();
		it.grad_z = rand_grad();
		item_q.push_back(it);
	endtask

	// plausible value for an attribute, with the odd wild one
	function automatic int phys_value(input int a);
		int r;
		r = $urandom_range(0, 19);
		if (a == ATTR_KIND) begin
			if (r < 9) return 1;
			if (r < 17) return 8;
			if (r == 17) return -1;
			return $urandom;
		end
		if (r == 0)
			return $urandom;
		if (a <= ATTR_POS2) return int'($urandom_range(0, 524288)) - 262144;
		if (a <= ATTR_VEL2) return int'($urandom_range(0, 262144)) - 131072;
		if (a == ATTR_DENS) return (r == 1) ? 0 : $urandom_range(32768, 131072);
		if (a == ATTR_SMOOTH) return $urandom_range(16384, 98304);
		if (a == ATTR_SOUND) return $urandom_range(65536, 655360);
		if (a == ATTR_MASS) return $urandom_range(6554, 65536);
		// force: near the rails now and then so accumulation saturates
		if (r == 1) return 32'sh7fff0000;
		if (r == 2) return 32'sh80010000;
		return int'($urandom_range(0, 131072)) - 65536;
	endfunction

	task automatic random_items(input int n);
		int r, i, j, k;
		for (int m = 0; m < n; m++) begin
			r = $urandom_range(0, 99);
			i = pool[$urandom_range(0, pool.size() - 1)];
			j = pool[$urandom_range(0, pool.size() - 1)];
			if (r < 35) begin
				put_pair(i, j);
			end else if (r < 58) begin
				k = $urandom_range(0, ATTR_FRC2);
				put_write(i, k, phys_value(k));
			end else if (r < 68) begin
				put_write($urandom_range(0, NPART - 1), $urandom_range(0, 15), $urandom);
			end else if (r < 95) begin
				if ($urandom_range(0, 9) == 0) begin
					put_read($urandom_range(0, NPART - 1), $urandom_range(14, 15));
				end else begin
					k = wr_keys[$urandom_range(0, wr_keys.size() - 1)];
					put_read(k % NPART, k / NPART);
				end
			end else begin
				item_q.push_back(make_item(CMD_IDLE, $urandom_range(0, NPART - 1),
					$urandom_range(0, NPART - 1), $urandom_range(0, 15), $urandom));
			end
		end
	endtask

	// wait until every item is in and every read has come back, then let
	// the last pair finish before touching the coefficients
	task automatic drain();
		while (item_q.size() > 0 || s_axis_tvalid || read_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_coeff(input logic idx, input int v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 17'(v);
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_ALPHA)
			alpha_m = v;
		else
			eta_m = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int g[4];
		// index set: small ones plus patterns that toggle every index bit
		for (int p = 0; p < 12; p++)
			pool.push_back(p);
		pool.push_back(341);
		pool.push_back(682);
		pool.push_back(1023);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// load every record in the pool
		quiet = 1'b1;
		foreach (pool[n])
			for (int a = 0; a <= ATTR_FRC2; a++)
				put_write(pool[n], a, phys_value(a));
		quiet = 1'b0;

		// directed: word extremes, kind sign, unused attributes, idle, pair corners
		put_write(1023, ATTR_FRC0, 32'sh80000000);
		put_write(1023, ATTR_FRC2, 32'sh7fffffff);
		put_read(1023, ATTR_FRC0);
		put_read(1023, ATTR_FRC2);
		put_write(5, ATTR_KIND, 32'h00000180);
		put_read(5, ATTR_KIND);
		put_write(5, ATTR_KIND, 8);
		put_write(7, 14, 32'h12345678);
		put_read(7, 14);
		put_read(0, 15);
		item_q.push_back(make_item(CMD_IDLE, 1023, 1023, 15, 32'hffffffff));
		// same particle twice
		put_pair(3, 3);
		// kinds that differ
		put_write(4, ATTR_KIND, 1);
		put_write(6, ATTR_KIND, 8);
		put_pair(4, 6);
		// approaching pair with zero densities: zero divisor
		put_write(8, ATTR_KIND, 1);
		put_write(9, ATTR_KIND, 1);
		put_write(8, ATTR_DENS, 0);
		put_write(9, ATTR_DENS, 0);
		put_write(8, ATTR_POS0, 65536);
		put_write(8, ATTR_VEL0, -65536);
		put_pair(8, 9);
		put_pair(1023, 0);
		put_pair(0, 1023);
		put_read(9, ATTR_FRC0);
		random_items(90);
		drain();

		// coefficient extremes and back, gaps off for part of it
		g = '{65536, 0, 1, 0};
		set_coeff(CFG_ALPHA, g[0]);
		set_coeff(CFG_ETA, g[1]);
		quiet = 1'b1;
		random_items(80);
		drain();
		quiet = 1'b0;
		set_coeff(CFG_ALPHA, 0);
		set_coeff(CFG_ETA, 65536);
		random_items(60);
		drain();
		set_coeff(CFG_ALPHA, g[2]);
		set_coeff(CFG_ETA, 1);
		random_items(40);
		drain();
		set_coeff(CFG_ALPHA, $urandom_range(0, 65536));
		set_coeff(CFG_ETA, $urandom_range(0, 65536));
		random_items(50);
		drain();

		if (n_err == 0 && read_q.size() == 0) begin
			$display("tb_sph_artificial_viscosity_pairs: done, clean");
		end else begin
			$display("tb_sph_artificial_viscosity_pairs: done, errors");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/sphav_pkg.sv
hdl/sphav_ram.sv
hdl/sph_artificial_viscosity_pairs.sv
bench/tb_sph_artificial_viscosity_pairs.sv
